// File: design/fmpd_pkg.sv
package fmpd_pkg;

  // Sample and iteration setup
  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // Datapath widths
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = PROD_W + 1;
  localparam int CW          = SUM_W + 3;        // covers CORDIC gain of about 1.65
  localparam int ANG_FRAC    = 24;               // 2^24 = pi
  localparam int ZW          = ANG_FRAC + 3;
  localparam int PHASE_SHIFT = 9;
  localparam int PHASE_W     = ZW - PHASE_SHIFT;
  localparam int GAIN_W      = 16;
  localparam int AUDIO_W     = 16;
  localparam int AUDIO_SHIFT = 8;
  localparam int MUL_W       = PHASE_W + GAIN_W + 1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Register map
  localparam int  PADDR_W            = 3;
  localparam int  PDATA_W            = 32;
  localparam logic REG_IDX_AUDIO_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2560);

  localparam logic signed [SAMPLE_BITS-1:0] UNIT_I = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ZW-1:0] ANG_PI =
    {{(ZW-ANG_FRAC-1){1'b0}}, 1'b1, {ANG_FRAC{1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          restart;
  } fmpd_in_t;

  typedef struct packed {
    logic signed [AUDIO_W-1:0] audio_sample;
    logic                      saturated;
  } fmpd_out_t;

  typedef enum logic [1:0] {
    FOLD_NONE,
    FOLD_POS_PI,
    FOLD_NEG_PI
  } fold_e;

  // Product folded into the right half plane
  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    fold_e                   fold;
  } fmpd_vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fmpd_qstat_t;

  // round(atan(2^-k) / pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_entry(input int k);
    logic signed [ZW-1:0] v;
    case (k)
      0:  v = ZW'(4194304);
      1:  v = ZW'(2476042);
      2:  v = ZW'(1308273);
      3:  v = ZW'(664100);
      4:  v = ZW'(333339);
      5:  v = ZW'(166832);
      6:  v = ZW'(83436);
      7:  v = ZW'(41721);
      8:  v = ZW'(20861);
      9:  v = ZW'(10430);
      10: v = ZW'(5215);
      11: v = ZW'(2608);
      12: v = ZW'(1304);
      13: v = ZW'(652);
      14: v = ZW'(326);
      15: v = ZW'(163);
      16: v = ZW'(81);
      17: v = ZW'(41);
      18: v = ZW'(20);
      19: v = ZW'(10);
      20: v = ZW'(5);
      21: v = ZW'(3);
      22: v = ZW'(1);
      23: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/fmpd_queue.sv
module fmpd_queue
  import fmpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fmpd_vec_t   data_i,
  input  logic        pop_i,
  output fmpd_vec_t   data_o,
  output fmpd_qstat_t stat_o
);

  fmpd_vec_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  always_comb begin
    stat_o.full  = (count_q == (QPTR_W+1)'(QDEPTH));
    stat_o.empty = (count_q == '0);
    data_o       = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/fmpd_front.sv
module fmpd_front
  import fmpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fmpd_in_t    in_data_i,
  input  fmpd_qstat_t qstat_i,
  output logic        push_o,
  output fmpd_vec_t   vec_o
);

  logic signed [SAMPLE_BITS-1:0] prev_i_q, prev_q_q;
  logic signed [SAMPLE_BITS-1:0] ref_i, ref_q;
  logic signed [PROD_W-1:0]      ii_q, qq_q, qi_q, iq_q;
  logic signed [SUM_W-1:0]       re, im;
  logic                          valid_a_q, valid_b_q;
  logic                          accept, a_move;
  fmpd_vec_t                     vec_d, vec_q;

  assign push_o     = valid_b_q && !qstat_i.full;
  assign a_move     = valid_a_q && (!valid_b_q || push_o);
  assign in_stall_o = valid_a_q && !a_move;
  assign accept     = in_valid_i && !in_stall_o;
  assign vec_o      = vec_q;

  // restart swaps in the unit vector as the previous sample
  always_comb begin
    ref_i = in_data_i.restart ? UNIT_I : prev_i_q;
    ref_q = in_data_i.restart ? '0 : prev_q_q;
  end

  // cur * conj(prev), then fold the left half plane over
  always_comb begin
    re = SUM_W'(ii_q) + SUM_W'(qq_q);
    im = SUM_W'(qi_q) - SUM_W'(iq_q);
    if (re[SUM_W-1]) begin
      vec_d.x    = -re;
      vec_d.y    = -im;
      vec_d.fold = im[SUM_W-1] ? FOLD_NEG_PI : FOLD_POS_PI;
    end else begin
      vec_d.x    = re;
      vec_d.y    = im;
      vec_d.fold = FOLD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      prev_i_q  <= UNIT_I;
      prev_q_q  <= '0;
    end else begin
      valid_a_q <= accept || (valid_a_q && !a_move);
      valid_b_q <= a_move || (valid_b_q && !push_o);
      if (accept) begin
        prev_i_q <= in_data_i.i_sample;
        prev_q_q <= in_data_i.q_sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ii_q <= in_data_i.i_sample * ref_i;
      qq_q <= in_data_i.q_sample * ref_q;
      qi_q <= in_data_i.q_sample * ref_i;
      iq_q <= in_data_i.i_sample * ref_q;
    end
    if (a_move) begin
      vec_q <= vec_d;
    end
  end

endmodule

// File: design/fmpd_back.sv
module fmpd_back
  import fmpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fmpd_qstat_t       qstat_i,
  input  fmpd_vec_t         vec_i,
  output logic              pop_o,
  input  logic [GAIN_W-1:0] gain_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fmpd_out_t         out_data_o
);

  localparam logic signed [MUL_W-1:0] AUD_MAX =
    {{(MUL_W-AUDIO_W+1){1'b0}}, {(AUDIO_W-1){1'b1}}};
  localparam logic signed [MUL_W-1:0] AUD_MIN =
    {{(MUL_W-AUDIO_W+1){1'b1}}, {(AUDIO_W-1){1'b0}}};
  localparam logic signed [ZW-1:0]    PHASE_RND = ZW'(1) <<< (PHASE_SHIFT-1);
  localparam logic signed [MUL_W-1:0] AUDIO_RND = MUL_W'(1) <<< (AUDIO_SHIFT-1);

  logic                 adv;
  logic                 v_q [NSTEPS+1];
  logic signed [CW-1:0] x_q [NSTEPS+1];
  logic signed [CW-1:0] y_q [NSTEPS+1];
  logic signed [ZW-1:0] z_q [NSTEPS+1];
  logic signed [ZW-1:0] z0;

  logic                    vp_q;
  logic signed [ZW-1:0]    z_rnd;
  logic signed [PHASE_W-1:0] phase;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [MUL_W-1:0] aud_rnd, aud_full;
  fmpd_out_t               out_d, out_q;
  logic                    out_valid_q;

  // whole back end freezes only while a finished item waits at the output
  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !qstat_i.empty;

  always_comb begin
    case (vec_i.fold)
      FOLD_POS_PI: z0 = ANG_PI;
      FOLD_NEG_PI: z0 = -ANG_PI;
      default:     z0 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= CW'(vec_i.x);
      y_q[0] <= CW'(vec_i.y);
      z_q[0] <= z0;
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    logic signed [CW-1:0] nx, ny;
    logic signed [ZW-1:0] nz;

    // a vector already on the axis passes through untouched
    always_comb begin
      nx = x_q[k];
      ny = y_q[k];
      nz = z_q[k];
      if (y_q[k] != '0) begin
        if (!y_q[k][CW-1]) begin
          nx = x_q[k] + (y_q[k] >>> k);
          ny = y_q[k] - (x_q[k] >>> k);
          nz = z_q[k] + atan_entry(k);
        end else begin
          nx = x_q[k] - (y_q[k] >>> k);
          ny = y_q[k] + (x_q[k] >>> k);
          nz = z_q[k] - atan_entry(k);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[k+1] <= nx;
        y_q[k+1] <= ny;
        z_q[k+1] <= nz;
      end
    end
  end

  // phase in units of pi/2^15, then gain
  always_comb begin
    z_rnd = z_q[NSTEPS] + PHASE_RND;
    phase = PHASE_W'(z_rnd >>> PHASE_SHIFT);
  end

  always_comb begin
    aud_rnd  = mul_q + AUDIO_RND;
    aud_full = aud_rnd >>> AUDIO_SHIFT;
    if (aud_full > AUD_MAX) begin
      out_d.audio_sample = AUD_MAX[AUDIO_W-1:0];
      out_d.saturated    = 1'b1;
    end else if (aud_full < AUD_MIN) begin
      out_d.audio_sample = AUD_MIN[AUDIO_W-1:0];
      out_d.saturated    = 1'b1;
    end else begin
      out_d.audio_sample = aud_full[AUDIO_W-1:0];
      out_d.saturated    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vp_q        <= v_q[NSTEPS];
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= MUL_W'(phase) * MUL_W'($signed({1'b0, gain_i}));
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/fm_polar_discriminator.sv
// Data path: product regs, folded vector, queue, CORDIC stages, gain product, output.
// Throughput: one item per cycle while not stalled; one CORDIC iteration per stage.
// A 4-entry queue sits between the multiply/fold front end and the CORDIC back end,
// so an output stall freezes only the back end until the queue fills.
// Reset: all valid bits clear, audio_gain = 2560, previous sample = (32767, 0).
module fm_polar_discriminator
  import fmpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fmpd_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fmpd_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [GAIN_W-1:0] gain_q;
  logic              gain_wr;
  fmpd_qstat_t       qstat;
  fmpd_vec_t         push_vec, pop_vec;
  logic              push, pop;

  assign pready  = 1'b1;
  assign gain_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_AUDIO_GAIN);
  assign prdata  = (paddr[2] == REG_IDX_AUDIO_GAIN) ? PDATA_W'(gain_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (gain_wr) begin
      gain_q <= pwdata[GAIN_W-1:0];
    end
  end

  fmpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .vec_o      (push_vec)
  );

  fmpd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_vec),
    .pop_i  (pop),
    .data_o (pop_vec),
    .stat_o (qstat)
  );

  fmpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .vec_i       (pop_vec),
    .pop_o       (pop),
    .gain_i      (gain_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/fmpd_checker.sv
module fmpd_checker
  import fmpd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fmpd_out_t out_data_o,
  input logic      pready
);

  localparam logic signed [AUDIO_W-1:0] AUD_MAX = {1'b0, {(AUDIO_W-1){1'b1}}};
  localparam logic signed [AUDIO_W-1:0] AUD_MIN = {1'b1, {(AUDIO_W-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // a clipped item must sit at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.audio_sample == AUD_MAX) || (out_data_o.audio_sample == AUD_MIN))
    else $error("saturated flag set off the rails");

  // non-overlapping implication, so the register has seen the reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind fm_polar_discriminator fmpd_checker u_fmpd_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fmpd_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int NUM_PHASES      = 8;
  localparam logic [PADDR_W-1:0] GAIN_ADDR = PADDR_W'(4 * REG_IDX_AUDIO_GAIN);
  localparam longint ANGLE_PI = 64'sd16777216;
  localparam real    PI_R     = 3.14159265358979;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  fmpd_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fmpd_out_t out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Angle per CORDIC step, 2^24 = pi
  longint atan_lut [24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  // Mirror of the block's state
  logic [GAIN_W-1:0]             gain_m   = GAIN_RESET;
  logic signed [SAMPLE_BITS-1:0] last_i_m = UNIT_I;
  logic signed [SAMPLE_BITS-1:0] last_q_m = '0;

  fmpd_in_t  if_samples[$];
  fmpd_out_t audio_expected[$];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  send_wait   = 0;
  int  recv_wait   = 0;
  bit  send_quiet  = 1'b0;
  bit  recv_quiet  = 1'b0;

  fm_polar_discriminator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  // Vectoring CORDIC angle of (x, y), 2^24 = pi
  function automatic longint cordic_angle(longint x0, longint y0);
    longint x, y, z, nx, ny;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < NSTEPS; k++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> k);
        ny = y - (x >>> k);
        z  = z + atan_lut[k];
      end else begin
        nx = x - (y >>> k);
        ny = y + (x >>> k);
        z  = z - atan_lut[k];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // Phase step of one sample against the stored one, scaled and clipped
  function automatic fmpd_out_t discriminate(fmpd_in_t s);
    longint ci, cq, li, lq, re, im, ph, aud;
    fmpd_out_t r;
    ci = s.i_sample;
    cq = s.q_sample;
    if (s.restart) begin
      last_i_m = UNIT_I;
      last_q_m = '0;
    end
    li = last_i_m;
    lq = last_q_m;
    re = ci * li + cq * lq;
    im = cq * li - ci * lq;
    last_i_m = s.i_sample;
    last_q_m = s.q_sample;
    ph  = (cordic_angle(re, im) + 256) >>> 9;
    aud = (ph * longint'(gain_m) + 128) >>> 8;
    r.saturated = 1'b0;
    if (aud > 32767) begin
      aud = 32767;
      r.saturated = 1'b1;
    end else if (aud < -32768) begin
      aud = -32768;
      r.saturated = 1'b1;
    end
    r.audio_sample = 16'(aud);
    return r;
  endfunction

  // Sample driver
  always @(posedge clk_i) begin : drive
    logic     nv;
    fmpd_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        audio_expected.push_back(discriminate(in_data));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (if_samples.size() > 0) begin
          nd = if_samples.pop_front();
          nv = 1'b1;
          send_wait = draw_wait(send_quiet);
          if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Audio monitor
  always @(posedge clk_i) begin : watch
    fmpd_out_t want;
    logic      ns;
    ns = 1'b0;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (audio_expected.size() == 0) begin
          flag($sformatf("unexpected audio item %0d/%0b",
                         out_data.audio_sample, out_data.saturated));
        end else begin
          want = audio_expected.pop_front();
          if (out_data.audio_sample !== want.audio_sample)
            flag($sformatf("audio_sample: expected %0d, got %0d",
                           want.audio_sample, out_data.audio_sample));
          if (out_data.saturated !== want.saturated)
            flag($sformatf("saturated: expected %0b, got %0b",
                           want.saturated, out_data.saturated));
        end
        recv_wait = draw_wait(recv_quiet);
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        ns = 1'b1;
      end
    end
    out_stall <= ns;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push(int i, int q, bit rs);
    fmpd_in_t s;
    s.i_sample = 16'(i);
    s.q_sample = 16'(q);
    s.restart  = rs;
    if_samples.push_back(s);
  endtask

  function automatic int to_q15(real v);
    int r;
    r = int'(v);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Mostly FM tones with random amplitude and deviation, some raw and corner noise
  task automatic load_random(int n);
    int  left, len, amp, kind;
    real ph, step;
    int  corner [5] = '{-32768, -1, 0, 1, 32767};
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len  = $urandom_range(4, 40);
        amp  = $urandom_range(1, 32767);
        ph   = (real'($urandom_range(0, 65535)) / 32768.0 - 1.0) * PI_R;
        step = (real'($urandom_range(0, 65535)) / 32768.0 - 1.0) * PI_R;
        if ($urandom_range(0, 2) != 0) step = step * 0.1;
        for (int k = 0; k < len && left > 0; k++) begin
          push(to_q15(amp * $cos(ph)), to_q15(amp * $sin(ph)),
               (k == 0) ? bit'($urandom_range(0, 1)) : 1'b0);
          ph = ph + step;
          left--;
        end
      end else if (kind < 9) begin
        push($urandom, $urandom, $urandom_range(0, 7) == 0);
        left--;
      end else begin
        push(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
             1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  // Wait on the falling edge so driver updates of this cycle are visible
  task automatic drain(int settle);
    while (if_samples.size() > 0 || in_valid || audio_expected.size() > 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= PDATA_W'(g);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gain_m = g;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[GAIN_W-1:0] !== g)
      flag($sformatf("audio_gain readback: expected %0d, got %0d", g, prdata[GAIN_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [GAIN_W-1:0] gain_plan [NUM_PHASES];
    gain_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd256, 16'd0, 16'd0, 16'd128, 16'd2560};
    gain_plan[4] = GAIN_W'($urandom_range(0, 65535));
    gain_plan[5] = GAIN_W'($urandom_range(0, 4096));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset gain
    push(32767, 0, 1'b1);          // same phase: zero step
    push(32767, 32767, 1'b0);      // 45 degrees: axis hit during iteration
    push(0, 32767, 1'b0);
    push(-32768, 0, 1'b1);         // negative real axis gives +pi
    push(-32768, -1, 1'b1);        // left half plane, below axis
    push(0, 0, 1'b0);              // zero sample
    push(12345, -2222, 1'b0);      // zero previous sample
    push(-32768, -32768, 1'b0);
    push(32767, -32768, 1'b0);
    push(-1, 1, 1'b0);
    push(1, 0, 1'b1);
    push(-1, 0, 1'b0);
    push(0, -32768, 1'b0);
    push(-32768, 32767, 1'b1);
    push(32767, 32767, 1'b1);
    push(32767, -32767, 1'b0);     // -90 degrees
    push(-1, -1, 1'b0);
    push(32767, 1, 1'b0);
    drain(4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_gain(gain_plan[p]);
      load_random(ITEMS_PER_PHASE);
      drain(4);
    end

    drain(SETTLE_CYCLES);
    if (audio_expected.size() > 0)
      flag($sformatf("%0d audio items never arrived", audio_expected.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
